// ----- hw/rtl/dual_channel_windowed_rms_unit_macros.svh -----
`ifndef DUAL_CHANNEL_WINDOWED_RMS_UNIT_MACROS_SVH
`define DUAL_CHANNEL_WINDOWED_RMS_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define DCWR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define DCWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dcwr_pkg.sv -----
`default_nettype none

package dcwr_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int WINDOW_BITS = 10;
    localparam int RMS_BITS    = 16;
    localparam int FRAC_SHIFT  = 8;

    localparam int PROD_BITS = 2 * SAMPLE_BITS;
    localparam int SUM_BITS  = PROD_BITS + WINDOW_BITS;
    localparam int DIV_BITS  = SUM_BITS + FRAC_SHIFT;
    localparam int ROOT_BITS = (DIV_BITS + 1) / 2;
    localparam int SQ_BITS   = 2 * ROOT_BITS;
    localparam int STEP_BITS = $clog2(DIV_BITS);
    localparam int CMP_BITS  = ROOT_BITS + RMS_BITS;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = (WINDOW_BITS > SAMPLE_BITS) ? WINDOW_BITS : SAMPLE_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASELINE_A    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASELINE_B    = 2'd2;

    localparam logic [WINDOW_BITS-1:0] WINDOW_LENGTH_RESET = WINDOW_BITS'(200);
    localparam logic [SAMPLE_BITS-1:0] BASELINE_RESET      = SAMPLE_BITS'(1700);
    localparam logic [RMS_BITS-1:0]    RMS_MAX             = {RMS_BITS{1'b1}};

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_a;
        logic [SAMPLE_BITS-1:0] sample_b;
    } sample_t;

    typedef struct packed {
        logic [RMS_BITS-1:0] rms_a;
        logic [RMS_BITS-1:0] rms_b;
    } result_t;

    typedef struct packed {
        logic load;
        logic accum;
        logic finish;
    } lane_ctl_t;

    typedef struct packed {
        logic                done;
        logic [RMS_BITS-1:0] rms;
    } lane_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dcwr_lane.sv -----
`default_nettype none

module dcwr_lane (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire dcwr_pkg::lane_ctl_t             ctl,
    input  wire logic [dcwr_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic [dcwr_pkg::SAMPLE_BITS-1:0] baseline,
    input  wire logic [dcwr_pkg::WINDOW_BITS-1:0] divisor,
    output dcwr_pkg::lane_stat_t                 stat
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_DIV  = 4'b0010,
        L_SQRT = 4'b0100,
        L_DONE = 4'b1000
    } lane_phase_t;

    lane_phase_t phase_reg;

    logic [dcwr_pkg::SAMPLE_BITS-1:0] diff_reg;
    logic [dcwr_pkg::PROD_BITS-1:0]   sq_reg;
    logic [dcwr_pkg::SUM_BITS-1:0]    sum_reg;
    logic [dcwr_pkg::SUM_BITS-1:0]    total;

    logic [dcwr_pkg::DIV_BITS-1:0]    q_reg;
    logic [dcwr_pkg::WINDOW_BITS-1:0] rem_reg;
    logic [dcwr_pkg::WINDOW_BITS:0]   trial;
    logic [dcwr_pkg::WINDOW_BITS:0]   trial_sub;
    logic                             div_ge;
    logic [dcwr_pkg::DIV_BITS-1:0]    q_next;

    logic [dcwr_pkg::SQ_BITS-1:0]     val_reg;
    logic [dcwr_pkg::ROOT_BITS-1:0]   root_reg;
    logic [dcwr_pkg::ROOT_BITS:0]     rem_sq_reg;
    logic [dcwr_pkg::ROOT_BITS+2:0]   sq_shifted;
    logic [dcwr_pkg::ROOT_BITS+2:0]   sq_trial;
    logic [dcwr_pkg::ROOT_BITS+2:0]   sq_diff;
    logic                             sq_ge;

    logic [dcwr_pkg::STEP_BITS-1:0]   step_reg;
    logic [dcwr_pkg::CMP_BITS-1:0]    root_ext;

    assign total = sum_reg + dcwr_pkg::SUM_BITS'(sq_reg);

    // Restoring division, one quotient bit per cycle, dividend shifted out MSB first.
    assign trial     = {rem_reg, q_reg[dcwr_pkg::DIV_BITS-1]};
    assign trial_sub = trial - {1'b0, divisor};
    assign div_ge    = (trial >= {1'b0, divisor});
    assign q_next    = {q_reg[dcwr_pkg::DIV_BITS-2:0], div_ge};

    // Restoring square root, two radicand bits and one root bit per cycle.
    assign sq_shifted = {rem_sq_reg, val_reg[dcwr_pkg::SQ_BITS-1 -: 2]};
    assign sq_trial   = {1'b0, root_reg, 2'b01};
    assign sq_diff    = sq_shifted - sq_trial;
    assign sq_ge      = (sq_shifted >= sq_trial);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            diff_reg <= (sample >= baseline) ? (sample - baseline) : (baseline - sample);
        end
        sq_reg <= dcwr_pkg::PROD_BITS'(diff_reg) * dcwr_pkg::PROD_BITS'(diff_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            phase_reg <= L_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            if (ctl.accum)
            begin
                sum_reg <= ctl.finish ? '0 : total;
            end
            if (ctl.finish)
            begin
                phase_reg <= L_DIV;
                step_reg  <= '0;
            end
            else
            begin
                unique case (phase_reg)
                    L_DIV:
                    begin
                        if (step_reg == dcwr_pkg::STEP_BITS'(dcwr_pkg::DIV_BITS - 1))
                        begin
                            phase_reg <= L_SQRT;
                            step_reg  <= '0;
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                    L_SQRT:
                    begin
                        if (step_reg == dcwr_pkg::STEP_BITS'(dcwr_pkg::ROOT_BITS - 1))
                        begin
                            phase_reg <= L_DONE;
                            step_reg  <= '0;
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                    L_IDLE, L_DONE:
                    begin
                        phase_reg <= phase_reg;
                    end
                    default:
                    begin
                        phase_reg <= L_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            q_reg   <= {total, {dcwr_pkg::FRAC_SHIFT{1'b0}}};
            rem_reg <= '0;
        end
        else if (phase_reg == L_DIV)
        begin
            q_reg   <= q_next;
            rem_reg <= div_ge ? trial_sub[dcwr_pkg::WINDOW_BITS-1:0]
                              : trial[dcwr_pkg::WINDOW_BITS-1:0];
            if (step_reg == dcwr_pkg::STEP_BITS'(dcwr_pkg::DIV_BITS - 1))
            begin
                val_reg    <= dcwr_pkg::SQ_BITS'(q_next);
                root_reg   <= '0;
                rem_sq_reg <= '0;
            end
        end
        else if (phase_reg == L_SQRT)
        begin
            val_reg    <= {val_reg[dcwr_pkg::SQ_BITS-3:0], 2'b00};
            root_reg   <= {root_reg[dcwr_pkg::ROOT_BITS-2:0], sq_ge};
            rem_sq_reg <= sq_ge ? sq_diff[dcwr_pkg::ROOT_BITS:0]
                                : sq_shifted[dcwr_pkg::ROOT_BITS:0];
        end
    end

    assign root_ext  = dcwr_pkg::CMP_BITS'(root_reg);
    assign stat.done = (phase_reg == L_DONE);
    assign stat.rms  = (root_ext > dcwr_pkg::CMP_BITS'(dcwr_pkg::RMS_MAX))
                     ? dcwr_pkg::RMS_MAX : root_ext[dcwr_pkg::RMS_BITS-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/dcwr_merge.sv -----
`default_nettype none

module dcwr_merge (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 calc,
    input  wire dcwr_pkg::lane_stat_t stat_a,
    input  wire dcwr_pkg::lane_stat_t stat_b,
    output logic                      pushed,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output dcwr_pkg::result_t         result_data
);

    logic              valid_reg;
    dcwr_pkg::result_t data_reg;
    logic              can_load;

    // The output register frees up in the same cycle its item is taken.
    assign can_load = !valid_reg || result_ready;
    assign pushed   = calc && stat_a.done && stat_b.done && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pushed)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pushed)
        begin
            data_reg.rms_a <= stat_a.rms;
            data_reg.rms_b <= stat_b.rms;
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dual_channel_windowed_rms_unit.sv -----
// Dual-channel windowed RMS unit. Each item carries one sample of channel A and one of
// channel B; each channel's lane squares the distance from its baseline and adds it to a
// sum of squares. Once window_length items have been taken (zero counts as one) the item
// yields one result, 16 * sqrt(sum / N) truncated for both channels, and the sums restart.
// An item that does not end a window passes through the square and accumulate states; an
// item that ends a window then waits for the bit-serial divider and the bit-serial square
// root that each lane runs in turn, one bit per cycle, on a quotient of D = 2 * SAMPLE_BITS
// + WINDOW_BITS + 8 bits and a root of ceil(D / 2) bits. A finished result waits in an
// output register, so the block takes the next item while it is pending. Configuration
// must be written only while the block is idle; the block itself does not enforce this.
`default_nettype none

module dual_channel_windowed_rms_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                sample_valid,
    output logic                                     sample_ready,
    input  wire dcwr_pkg::sample_t                   sample_data,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output dcwr_pkg::result_t                        result_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [dcwr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [dcwr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SQUARE = 4'b0010,
        S_ACCUM  = 4'b0100,
        S_CALC   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [dcwr_pkg::WINDOW_BITS-1:0] window_length_reg;
    logic [dcwr_pkg::SAMPLE_BITS-1:0] baseline_a_reg;
    logic [dcwr_pkg::SAMPLE_BITS-1:0] baseline_b_reg;

    logic [dcwr_pkg::WINDOW_BITS-1:0] samples_reg;
    logic [dcwr_pkg::WINDOW_BITS-1:0] count_inc;
    logic [dcwr_pkg::WINDOW_BITS-1:0] n_eff;
    logic [dcwr_pkg::WINDOW_BITS-1:0] n_reg;
    logic                             end_reg;
    logic                             window_end;
    logic                             accept;
    logic                             pushed;

    dcwr_pkg::lane_ctl_t  ctl;
    dcwr_pkg::lane_stat_t stat_a;
    dcwr_pkg::lane_stat_t stat_b;

    assign sample_ready = (state_reg == S_IDLE);
    assign accept       = sample_valid && sample_ready;

    assign n_eff      = (window_length_reg == '0) ? dcwr_pkg::WINDOW_BITS'(1) : window_length_reg;
    assign count_inc  = samples_reg + dcwr_pkg::WINDOW_BITS'(1);
    // The count wraps at the top of its range, which also ends the window.
    assign window_end = (count_inc == '0) || (count_inc >= n_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= dcwr_pkg::WINDOW_LENGTH_RESET;
            baseline_a_reg    <= dcwr_pkg::BASELINE_RESET;
            baseline_b_reg    <= dcwr_pkg::BASELINE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dcwr_pkg::CFG_WINDOW_LENGTH:
                begin
                    window_length_reg <= cfg_data[dcwr_pkg::WINDOW_BITS-1:0];
                end
                dcwr_pkg::CFG_BASELINE_A:
                begin
                    baseline_a_reg <= cfg_data[dcwr_pkg::SAMPLE_BITS-1:0];
                end
                dcwr_pkg::CFG_BASELINE_B:
                begin
                    baseline_b_reg <= cfg_data[dcwr_pkg::SAMPLE_BITS-1:0];
                end
                default:
                begin
                    window_length_reg <= window_length_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            samples_reg <= '0;
            end_reg     <= 1'b0;
            n_reg       <= dcwr_pkg::WINDOW_BITS'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                samples_reg <= window_end ? '0 : count_inc;
                end_reg     <= window_end;
                n_reg       <= n_eff;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                state_next = end_reg ? S_CALC : S_IDLE;
            end
            S_CALC:
            begin
                if (pushed)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ctl.load   = accept;
    assign ctl.accum  = (state_reg == S_ACCUM);
    assign ctl.finish = (state_reg == S_ACCUM) && end_reg;

    dcwr_lane u_lane_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sample   (sample_data.sample_a),
        .baseline (baseline_a_reg),
        .divisor  (n_reg),
        .stat     (stat_a)
    );

    dcwr_lane u_lane_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sample   (sample_data.sample_b),
        .baseline (baseline_b_reg),
        .divisor  (n_reg),
        .stat     (stat_b)
    );

    dcwr_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .calc         (state_reg == S_CALC),
        .stat_a       (stat_a),
        .stat_b       (stat_b),
        .pushed       (pushed),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/dcwr_checker.sv -----
`default_nettype none

`include "dual_channel_windowed_rms_unit_macros.svh"

module dcwr_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                sample_valid,
    input wire logic                                sample_ready,
    input wire dcwr_pkg::sample_t                   sample_data,
    input wire logic                                result_valid,
    input wire logic                                result_ready,
    input wire dcwr_pkg::result_t                   result_data,
    input wire logic                                cfg_wr_en,
    input wire logic [dcwr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input wire logic [dcwr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    logic accepted;
    logic cfg_seen;

    assign accepted = sample_valid && sample_ready;
    // Configuration traffic is watched but places no constraint on the checks below.
    assign cfg_seen = cfg_wr_en && (cfg_index != '0 || cfg_data != '0 || sample_data != '0);

    // A pending result holds until it is taken.
    `DCWR_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_data), "result changed while stalled")

    // Every item goes through the square and accumulate steps before the next one enters.
    `DCWR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accepted, !sample_ready ##1 !sample_ready, "input taken again too early")

    // A new result comes only out of a window calculation, during which input is held off.
    `DCWR_ASSERT_NOW(a_result_from_calc, clk, rst_n, $rose(result_valid), $past(!sample_ready), "result appeared without a calculation")

    // Input is never held off right after reset, whatever the configuration port does.
    `DCWR_ASSERT_NOW(a_ready_after_reset, clk, rst_n, $rose(rst_n) || ($past(!rst_n) && cfg_seen), sample_ready, "not ready after reset")

endmodule

bind dual_channel_windowed_rms_unit dcwr_checker u_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dcwr_pkg::*;

    // Index 3 decodes to no register; writes to it must be dropped.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {SAMPLE_BITS{1'b0}};
    localparam logic [CFG_DATA_BITS-1:0] LONGEST_WINDOW = CFG_DATA_BITS'({WINDOW_BITS{1'b1}});
    localparam int ITEM_TOTAL     = 1500;
    localparam int WINDOWS_WANTED = 60;
    localparam int SETTLE_CYCLES  = 80;
    localparam int STALL_LIMIT    = 3000;

    class rms_window_scoreboard;
        logic [WINDOW_BITS-1:0] window_len = WINDOW_LENGTH_RESET;
        logic [SAMPLE_BITS-1:0] base_a = BASELINE_RESET;
        logic [SAMPLE_BITS-1:0] base_b = BASELINE_RESET;
        logic [63:0] sq_sum_a = '0;
        logic [63:0] sq_sum_b = '0;
        logic [WINDOW_BITS-1:0] taken = '0;
        result_t rms_due[$];
        int windows_closed = 0;
        int errors = 0;

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_WINDOW_LENGTH: window_len = val[WINDOW_BITS-1:0];
                CFG_BASELINE_A:    base_a = val[SAMPLE_BITS-1:0];
                CFG_BASELINE_B:    base_b = val[SAMPLE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] dist_sq(logic [SAMPLE_BITS-1:0] s, logic [SAMPLE_BITS-1:0] b);
            logic [63:0] d;
            d = (s >= b) ? 64'(s - b) : 64'(b - s);
            return d * d;
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] trial;
            root = '0;
            for (int i = 31; i >= 0; i--)
            begin
                trial = root | (64'd1 << i);
                if (trial * trial <= v)
                    root = trial;
            end
            return root;
        endfunction

        function logic [RMS_BITS-1:0] window_rms(logic [63:0] sum, logic [63:0] n);
            logic [63:0] root;
            root = floor_sqrt((sum << FRAC_SHIFT) / n);
            return (root > 64'(RMS_MAX)) ? RMS_MAX : root[RMS_BITS-1:0];
        endfunction

        function void note_sample(sample_t s);
            logic [WINDOW_BITS-1:0] n;
            result_t r;
            // A zero window length behaves as a window of one item.
            n = (window_len == 0) ? WINDOW_BITS'(1) : window_len;
            sq_sum_a += dist_sq(s.sample_a, base_a);
            sq_sum_b += dist_sq(s.sample_b, base_b);
            taken = taken + 1'b1;
            // The divisor is whatever window length is in force when the window closes.
            if (taken == 0 || taken >= n)
            begin
                r.rms_a = window_rms(sq_sum_a, 64'(n));
                r.rms_b = window_rms(sq_sum_b, 64'(n));
                rms_due.push_back(r);
                windows_closed++;
                sq_sum_a = '0;
                sq_sum_b = '0;
                taken = '0;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (rms_due.size() == 0)
            begin
                $error("result rms_a=%0d rms_b=%0d arrived with none pending",
                       got.rms_a, got.rms_b);
                errors++;
                return;
            end
            want = rms_due.pop_front();
            if (got.rms_a !== want.rms_a)
            begin
                $error("rms_a: expected %0d, got %0d", want.rms_a, got.rms_a);
                errors++;
            end
            if (got.rms_b !== want.rms_b)
            begin
                $error("rms_b: expected %0d, got %0d", want.rms_b, got.rms_b);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    sample_t sample_data = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_WINDOW_LENGTH;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    bit steady = 1'b0;
    int items_sent = 0;
    rms_window_scoreboard sb = new();

    dual_channel_windowed_rms_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Results are checked before the new item is noted, so a stray result can never
    // match a prediction made on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                sb.write_reg(cfg_index, cfg_data);
            if (result_valid && result_ready)
                sb.check_result(result_data);
            if (sample_valid && sample_ready)
                sb.note_sample(sample_data);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (cfg_wr_en || (sample_valid && sample_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        int stall;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    task automatic send_sample(input sample_t s);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_data <= s;
        do @(posedge clk); while (!sample_ready);
        @(negedge clk);
        items_sent++;
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic program_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    // Holds off the sender until every window result is in, then lets any item
    // still in the block finish.
    task automatic settle();
        sample_valid <= 1'b0;
        while (sb.rms_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_window();
        logic [CFG_DATA_BITS-1:0] v;
        int r;
        r = $urandom_range(0, 19);
        // Random upper bits check that the window field is masked.
        v = CFG_DATA_BITS'($urandom);
        case (r)
            0:       v[WINDOW_BITS-1:0] = '0;
            1:       v[WINDOW_BITS-1:0] = WINDOW_LENGTH_RESET;
            2:       v[WINDOW_BITS-1:0] = WINDOW_BITS'($urandom_range(17, 300));
            default: v[WINDOW_BITS-1:0] = WINDOW_BITS'($urandom_range(1, 16));
        endcase
        return v;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_baseline();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return SAMPLE_MIN;
        if (r == 1)
            return SAMPLE_MAX;
        return SAMPLE_BITS'($urandom);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_level(logic [SAMPLE_BITS-1:0] base);
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        if (r == 1)
        begin
            v = int'(base) + int'($urandom_range(0, 6)) - 3;
            if (v < 0)
                v = 0;
            if (v > int'(SAMPLE_MAX))
                v = int'(SAMPLE_MAX);
            return SAMPLE_BITS'(v);
        end
        return SAMPLE_BITS'($urandom);
    endfunction

    initial
    begin
        int phase;
        phase = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset baselines and a 200-item window: none of these items closes a window.
        send_sample(sample_t'{SAMPLE_MIN, SAMPLE_MIN});
        send_sample(sample_t'{SAMPLE_MAX, SAMPLE_MAX});
        send_sample(sample_t'{12'd1700, 12'd1700});
        send_sample(sample_t'{SAMPLE_MIN, SAMPLE_MAX});
        send_sample(sample_t'{SAMPLE_MAX, SAMPLE_MIN});
        send_sample(sample_t'{12'd1699, 12'd1701});
        send_sample(sample_t'{12'hAAA, 12'h555});
        send_sample(sample_t'{12'h555, 12'hAAA});
        settle();

        // Shortening the window below the count already taken closes it on the next item.
        program_reg(CFG_WINDOW_LENGTH, 12'd5);
        cfg_wr_en <= 1'b0;
        send_sample(sample_t'{12'd100, 12'd3000});
        settle();

        program_reg(CFG_WINDOW_LENGTH, 12'd0);
        program_reg(CFG_BASELINE_A, SAMPLE_MIN);
        program_reg(CFG_BASELINE_B, SAMPLE_MAX);
        program_reg(CFG_SPARE, 12'd7);
        cfg_wr_en <= 1'b0;
        send_sample(sample_t'{SAMPLE_MAX, SAMPLE_MIN});
        send_sample(sample_t'{SAMPLE_MIN, SAMPLE_MAX});
        send_sample(sample_t'{12'd1, 12'd4094});
        settle();

        program_reg(CFG_WINDOW_LENGTH, 12'hC03);
        cfg_wr_en <= 1'b0;
        send_sample(sample_t'{SAMPLE_MAX, SAMPLE_MIN});
        send_sample(sample_t'{12'd2048, 12'd2047});
        send_sample(sample_t'{SAMPLE_MIN, SAMPLE_MAX});
        send_sample(sample_t'{12'h800, 12'h7FF});
        send_sample(sample_t'{SAMPLE_MAX, SAMPLE_MAX});
        send_sample(sample_t'{SAMPLE_MIN, SAMPLE_MIN});
        settle();

        while (items_sent < ITEM_TOTAL || sb.windows_closed < WINDOWS_WANTED)
        begin
            phase++;
            steady = ($urandom_range(0, 3) == 0);
            if (phase == 4)
            begin
                // Flush the running window, then fill the longest window mostly with the
                // largest distances so the sums come close to their maximum.
                program_reg(CFG_WINDOW_LENGTH, '0);
                cfg_wr_en <= 1'b0;
                send_sample(sample_t'{pick_level(sb.base_a), pick_level(sb.base_b)});
                settle();
                program_reg(CFG_WINDOW_LENGTH, LONGEST_WINDOW);
                program_reg(CFG_BASELINE_A, SAMPLE_MIN);
                program_reg(CFG_BASELINE_B, SAMPLE_MAX);
                cfg_wr_en <= 1'b0;
                repeat (int'(LONGEST_WINDOW))
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_sample(sample_t'{pick_level(sb.base_a), pick_level(sb.base_b)});
                    else
                        send_sample(sample_t'{SAMPLE_MAX, SAMPLE_MIN});
                end
            end
            else
            begin
                program_reg(CFG_WINDOW_LENGTH, pick_window());
                if ($urandom_range(0, 1) == 1)
                    program_reg(CFG_BASELINE_A, pick_baseline());
                if ($urandom_range(0, 1) == 1)
                    program_reg(CFG_BASELINE_B, pick_baseline());
                cfg_wr_en <= 1'b0;
                repeat ($urandom_range(4, 40))
                    send_sample(sample_t'{pick_level(sb.base_a), pick_level(sb.base_b)});
            end
            settle();
        end

        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
